[sv/phavc_pkg.sv]
`timescale 1ns / 1ps

package phavc_pkg;

   // Sizing of the averaging ring and the sample path
   localparam int AVG_DEPTH   = 10;
   localparam int SAMPLE_BITS = 10;

   // Fixed field widths
   localparam int ADC_W      = 10;
   localparam int CAL_W      = 10;
   localparam int PH_W       = 11;
   localparam int CENTI_W    = 16;
   localparam int WHOLE_W    = 8;
   localparam int HUND_W     = 7;
   localparam int MODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // Stream widths; tdata widths padded to whole bytes
   localparam int REQ_TDATA_W = ((ADC_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = CENTI_W + WHOLE_W + HUND_W + MODE_W + 2;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_TUSER_W = 1;

   // Derived datapath widths
   localparam int SLOT_W       = $clog2(AVG_DEPTH);
   localparam int SUM_W        = $clog2(AVG_DEPTH * (2 ** SAMPLE_BITS - 1) + 1);
   localparam int NUM_POS_MAX  = 3 * (2 ** SAMPLE_BITS - 1) + 4 * (2 ** CAL_W - 1);
   localparam int NUM_NEG_MAX  = 7 * (2 ** CAL_W - 1);
   localparam int NUM_MAX      = (NUM_POS_MAX > NUM_NEG_MAX) ? NUM_POS_MAX : NUM_NEG_MAX;
   localparam int NUM_W        = $clog2(NUM_MAX + 1);
   localparam int CENTI_SCALE  = 100;
   localparam int FRAC_W       = $clog2(CENTI_SCALE);
   localparam int R100_W       = CAL_W + FRAC_W;
   localparam int CENTI_FULL_W = NUM_W + FRAC_W;
   localparam int DEPTH_W      = $clog2(AVG_DEPTH + 1);
   localparam int DVS_W        = (CAL_W > DEPTH_W) ? CAL_W : DEPTH_W;
   localparam int DIVD_W       = (NUM_W > FRAC_W) ? NUM_W : FRAC_W;
   localparam int STEP_W       = $clog2(DIVD_W + 1);

   // Saturation values
   localparam int CENTI_MAX = 65535;
   localparam int WHOLE_MAX = 255;
   localparam int HUND_SAT  = CENTI_MAX % CENTI_SCALE;

   // Register reset values
   localparam int CALIB_RST  = 0;
   localparam int TARGET_RST = 700;
   localparam int HYST_RST   = 20;
   localparam int CRIT_RST   = 600;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CALIB_PH4   = 3'd0,
      CSR_CALIB_PH7   = 3'd1,
      CSR_TARGET_PH   = 3'd2,
      CSR_HYSTERESIS  = 3'd3,
      CSR_CRITICAL_PH = 3'd4
   } csr_idx_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_IDLE = 2'd0,
      MODE_ACID = 2'd1,
      MODE_BASE = 2'd2
   } valve_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG_WAIT,
      ST_NUM_GO,
      ST_QUO_WAIT,
      ST_FRAC_GO,
      ST_FRAC_WAIT,
      ST_SCALE,
      ST_CTRL
   } seq_state_type;

   // Command to the bit-serial divider
   typedef struct packed {
      logic              start;
      logic [DVS_W-1:0]  rem_init;
      logic [DIVD_W-1:0] dividend;
      logic [DVS_W-1:0]  divisor;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   // Status and result of the divider
   typedef struct packed {
      logic              busy;
      logic              done;
      logic [DIVD_W-1:0] quotient;
      logic [DVS_W-1:0]  remainder;
   } div_rsp_type;

endpackage

[sv/phavc_div.sv]
`timescale 1ns / 1ps

module phavc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  phavc_pkg::div_req_type div_req,
   output phavc_pkg::div_rsp_type div_rsp
);
   import phavc_pkg::*;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] count_ff, count_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DIVD_W-1:0] sh_ff, sh_in;
   logic [DVS_W+1:0]  trial;
   logic              ge;

   // Trial subtract of the divisor from the partial remainder plus next bit
   always_comb begin
      trial = {1'b0, rem_ff, sh_ff[DIVD_W-1]} - {2'b00, dvs_ff};
      ge    = !trial[DVS_W+1];
   end

   // One quotient bit per cycle; dividend bits leave at the top,
   // quotient bits enter at the bottom
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      sh_in    = sh_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         count_in = div_req.steps;
         rem_in   = div_req.rem_init;
         dvs_in   = div_req.divisor;
         sh_in    = div_req.dividend;
      end else if (busy_ff) begin
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
            rem_in   = ge ? trial[DVS_W-1:0] : {rem_ff[DVS_W-2:0], sh_ff[DIVD_W-1]};
            sh_in    = {sh_ff[DIVD_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   // Datapath, no reset
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      sh_ff  <= sh_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = busy_ff && (count_ff == '0);
   assign div_rsp.quotient  = sh_ff;
   assign div_rsp.remainder = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (dvs_ff != '0))
      else $error("divider running with zero divisor");

   a_done_releases: assert property (@(posedge clock) disable iff (reset)
      (div_rsp.done && !div_req.start) |=> !busy_ff)
      else $error("divider still busy after done");

endmodule

[sv/ph_average_calibrate_valve_control_unit.sv]
`timescale 1ns / 1ps

// pH meter front end with a three-state valve controller.
// req_ channel: one beat carries one converter sample. It enters a ten-deep
// ring whose running sum is kept; the average, the two-point calibration
// quotient and its two decimal places come out of one shared divider that
// resolves one quotient bit per cycle.
// rsp_ channel: one beat per sample with pH in hundredths (saturated), the
// whole part, the hundredths and the valve state; tuser flags equal
// calibration points.
// csr_ port: plain writes, index 0..4 = calib_ph4, calib_ph7, target_ph,
// hysteresis, critical_ph; other indexes are dropped. Write while idle.
// A sample is taken only while the sequencer is idle; with equal calibration
// points the two calibration divisions are skipped.
// A finished result waits in the output register; the next sample is still
// taken and processed, and the sequencer holds in its last state only while
// the previous result has not been taken.
// Reset clears the ring, the running sum, the valve state and the registers
// to their defaults (700, 20, 600 for the thresholds).

module ph_average_calibrate_valve_control_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [phavc_pkg::REQ_TDATA_W-1:0]  req_tdata,  // [9:0] adc_sample
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] ph_centi, [23:16] ph_whole, [30:24] ph_hundredths,
   // [32:31] valve_mode, [33] acid_valve, [34] base_valve
   output logic [phavc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic [phavc_pkg::RSP_TUSER_W-1:0]  rsp_tuser,  // [0] calib_error
   input  logic                               csr_we,
   input  logic [phavc_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  logic [phavc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import phavc_pkg::*;

   // Configuration
   logic [CAL_W-1:0] calib_ph4_ff, calib_ph7_ff;
   logic [PH_W-1:0]  target_ph_ff, hysteresis_ff, critical_ph_ff;

   // Ring and running sum
   logic [SAMPLE_BITS-1:0] ring_ff [AVG_DEPTH];
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   req_acc;

   // Sequencer
   seq_state_type state_ff, state_in;
   div_req_type   div_req;
   div_rsp_type   div_rsp;

   // Calibration datapath
   logic [SAMPLE_BITS-1:0]  avg;
   logic [NUM_W-1:0]        num_pos, num_neg, num;
   logic [CAL_W-1:0]        den;
   logic [R100_W-1:0]       r100;
   logic [NUM_W-1:0]        q_ff;
   logic                    err_ff;
   logic [FRAC_W-1:0]       frac;
   logic [CENTI_FULL_W-1:0] centi_full;
   logic                    sat;
   logic [CENTI_W-1:0]      centi_ff;
   logic [WHOLE_W-1:0]      whole_ff;
   logic [HUND_W-1:0]       hund_ff;

   // Controller
   valve_mode_type     mode_ff, mode_in;
   logic [CENTI_W-1:0] up_th, down_th, crit_th;

   // Output register
   logic               out_room, out_load;
   logic               rsp_tvalid_ff;
   logic [CENTI_W-1:0] out_centi_ff;
   logic [WHOLE_W-1:0] out_whole_ff;
   logic [HUND_W-1:0]  out_hund_ff;
   valve_mode_type     out_mode_ff;
   logic               out_err_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ph4_ff   <= CAL_W'(CALIB_RST);
         calib_ph7_ff   <= CAL_W'(CALIB_RST);
         target_ph_ff   <= PH_W'(TARGET_RST);
         hysteresis_ff  <= PH_W'(HYST_RST);
         critical_ph_ff <= PH_W'(CRIT_RST);
      end else if (csr_we) begin
         case (csr_idx_type'(csr_addr))
            CSR_CALIB_PH4:   calib_ph4_ff   <= csr_wdata[CAL_W-1:0];
            CSR_CALIB_PH7:   calib_ph7_ff   <= csr_wdata[CAL_W-1:0];
            CSR_TARGET_PH:   target_ph_ff   <= csr_wdata[PH_W-1:0];
            CSR_HYSTERESIS:  hysteresis_ff  <= csr_wdata[PH_W-1:0];
            CSR_CRITICAL_PH: critical_ph_ff <= csr_wdata[PH_W-1:0];
            default: ;
         endcase
      end
   end

   // Ring update: overwrite oldest entry, adjust running sum
   assign req_acc = req_tvalid && req_tready;
   assign sample  = SAMPLE_BITS'(req_tdata[ADC_W-1:0]);
   assign sum_in  = sum_ff - SUM_W'(ring_ff[slot_ff]) + SUM_W'(sample);
   assign slot_in = (slot_ff == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AVG_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         slot_ff <= '0;
         sum_ff  <= '0;
      end else if (req_acc) begin
         ring_ff[slot_ff] <= sample;
         slot_ff          <= slot_in;
         sum_ff           <= sum_in;
      end
   end

   // Calibration numerator and denominator
   always_comb begin
      avg     = div_rsp.quotient[SAMPLE_BITS-1:0];
      num_pos = (NUM_W'(avg) << 1) + NUM_W'(avg) + (NUM_W'(calib_ph7_ff) << 2);
      num_neg = (NUM_W'(calib_ph4_ff) << 3) - NUM_W'(calib_ph4_ff);
      num     = (num_pos >= num_neg) ? num_pos - num_neg : num_neg - num_pos;
      den     = (calib_ph7_ff >= calib_ph4_ff) ? calib_ph7_ff - calib_ph4_ff
                                               : calib_ph4_ff - calib_ph7_ff;
      r100    = R100_W'(div_rsp.remainder[CAL_W-1:0]) * R100_W'(CENTI_SCALE);
   end

   // Sequencer next state
   assign out_room = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_AVG_WAIT;
         ST_AVG_WAIT:  if (div_rsp.done) state_in = ST_NUM_GO;
         ST_NUM_GO:    state_in = (den == '0) ? ST_SCALE : ST_QUO_WAIT;
         ST_QUO_WAIT:  if (div_rsp.done) state_in = ST_FRAC_GO;
         ST_FRAC_GO:   state_in = ST_FRAC_WAIT;
         ST_FRAC_WAIT: if (div_rsp.done) state_in = ST_SCALE;
         ST_SCALE:     state_in = ST_CTRL;
         ST_CTRL:      if (out_room) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer outputs: handshake and divider commands
   always_comb begin
      req_tready       = 1'b0;
      out_load         = 1'b0;
      div_req.start    = 1'b0;
      div_req.rem_init = '0;
      div_req.dividend = '0;
      div_req.divisor  = DVS_W'(den);
      div_req.steps    = STEP_W'(NUM_W);
      case (state_ff)
         ST_IDLE: begin
            // sum / AVG_DEPTH, high part preloaded as it is below the divisor
            req_tready       = 1'b1;
            div_req.start    = req_tvalid;
            div_req.rem_init = DVS_W'(sum_in >> SAMPLE_BITS);
            div_req.dividend = DIVD_W'(sum_in[SAMPLE_BITS-1:0]) << (DIVD_W - SAMPLE_BITS);
            div_req.divisor  = DVS_W'(AVG_DEPTH);
            div_req.steps    = STEP_W'(SAMPLE_BITS);
         end
         ST_NUM_GO: begin
            // num / den
            div_req.start    = (den != '0);
            div_req.dividend = DIVD_W'(num) << (DIVD_W - NUM_W);
            div_req.steps    = STEP_W'(NUM_W);
         end
         ST_FRAC_GO: begin
            // 100 * remainder / den gives the two decimal places
            div_req.start    = 1'b1;
            div_req.rem_init = DVS_W'(r100 >> FRAC_W);
            div_req.dividend = DIVD_W'(r100[FRAC_W-1:0]) << (DIVD_W - FRAC_W);
            div_req.steps    = STEP_W'(FRAC_W);
         end
         ST_CTRL:  out_load = out_room;
         default: ;
      endcase
   end

   phavc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Scale and saturate
   always_comb begin
      frac       = div_rsp.quotient[FRAC_W-1:0];
      centi_full = CENTI_FULL_W'(q_ff) * CENTI_FULL_W'(CENTI_SCALE) + CENTI_FULL_W'(frac);
      sat        = err_ff || (centi_full > CENTI_FULL_W'(CENTI_MAX));
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_NUM_GO) begin
         err_ff <= (den == '0);
      end
      if (state_ff == ST_FRAC_GO) begin
         q_ff <= div_rsp.quotient[NUM_W-1:0];
      end
      if (state_ff == ST_SCALE) begin
         centi_ff <= sat ? CENTI_W'(CENTI_MAX) : centi_full[CENTI_W-1:0];
         whole_ff <= (err_ff || (q_ff > NUM_W'(WHOLE_MAX))) ? WHOLE_W'(WHOLE_MAX)
                                                           : q_ff[WHOLE_W-1:0];
         hund_ff  <= sat ? HUND_W'(HUND_SAT) : HUND_W'(frac);
      end
   end

   // Hysteresis step; idle tests upper then critical so critical wins
   always_comb begin
      up_th   = CENTI_W'(target_ph_ff) + CENTI_W'(hysteresis_ff);
      down_th = CENTI_W'(target_ph_ff) - CENTI_W'(hysteresis_ff);
      crit_th = CENTI_W'(critical_ph_ff);
      mode_in = mode_ff;
      case (mode_ff)
         MODE_IDLE: begin
            if (centi_ff >= up_th) mode_in = MODE_ACID;
            if (centi_ff <= crit_th) mode_in = MODE_BASE;
         end
         MODE_ACID: if (centi_ff <= down_th) mode_in = MODE_IDLE;
         MODE_BASE: if (centi_ff >= down_th) mode_in = MODE_IDLE;
         default:   mode_in = mode_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else if (out_load) begin
         mode_ff       <= mode_in;
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   // Output payload, no reset
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_centi_ff <= centi_ff;
         out_whole_ff <= whole_ff;
         out_hund_ff  <= hund_ff;
         out_mode_ff  <= mode_in;
         out_err_ff   <= err_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({out_mode_ff == MODE_BASE, out_mode_ff == MODE_ACID,
                                     out_mode_ff, out_hund_ff, out_whole_ff, out_centi_ff});
   assign rsp_tuser  = RSP_TUSER_W'(out_err_ff);

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_err_saturates: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && out_err_ff) |->
         ((out_centi_ff == CENTI_W'(CENTI_MAX)) && (out_whole_ff == WHOLE_W'(WHOLE_MAX))
          && (out_hund_ff == HUND_W'(HUND_SAT))))
      else $error("calibration error beat not saturated");

   a_hund_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (out_hund_ff < HUND_W'(CENTI_SCALE)))
      else $error("hundredths out of range");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (slot_ff < SLOT_W'(AVG_DEPTH)) && (state_ff == ST_AVG_WAIT))
      else $error("ring slot or sequencer wrong after sample");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
   import phavc_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 9;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1640;
   localparam int PHASES       = 8;
   localparam int SETTLE       = 2;
   localparam int DRAIN_CYCLES = 80;

   // Indexes with no register behind them; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_5 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_7 = 3'd7;

   typedef struct {
      logic [CENTI_W-1:0] centi;
      logic [WHOLE_W-1:0] whole;
      logic [HUND_W-1:0]  hund;
      valve_mode_type     mode;
      logic               acid;
      logic               base;
      logic               err;
   } ph_reading_type;

   typedef struct {
      logic                  is_cfg;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] val;
      logic                  typed;
      ph_reading_type        want;
   } stim_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_addr   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   ph_average_calibrate_valve_control_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Shadow of the block: ring, slot, valve state and registers
   logic [SAMPLE_BITS-1:0] ring_copy [AVG_DEPTH];
   int                     slot_copy;
   valve_mode_type         mode_copy;
   logic [CAL_W-1:0]       cal4_copy;
   logic [CAL_W-1:0]       cal7_copy;
   logic [PH_W-1:0]        target_copy;
   logic [PH_W-1:0]        hyst_copy;
   logic [PH_W-1:0]        crit_copy;

   ph_reading_type pending_readings [$];
   stim_row_type   directed_rows [$];

   int snd_idle = 9;
   int rcv_idle = 63;
   int mismatches;
   int samples_sent;
   int readings_seen;
   int writes_done;
   int acid_seen;
   int base_seen;
   int err_seen;
   int cycle_count;

   initial begin
      for (int i = 0; i < AVG_DEPTH; i++) ring_copy[i] = '0;
      slot_copy   = 0;
      mode_copy   = MODE_IDLE;
      cal4_copy   = CAL_W'(CALIB_RST);
      cal7_copy   = CAL_W'(CALIB_RST);
      target_copy = PH_W'(TARGET_RST);
      hyst_copy   = PH_W'(HYST_RST);
      crit_copy   = PH_W'(CRIT_RST);
   end

   // Advance the shadow by one sample and work out the reading it gives
   function automatic ph_reading_type ph_predict(input logic [ADC_W-1:0] sample);
      ph_reading_type r;
      int i, sum, avg, snum, num, den, centi, whole, up, down;
      ring_copy[slot_copy] = sample[SAMPLE_BITS-1:0];
      slot_copy = (slot_copy == AVG_DEPTH - 1) ? 0 : slot_copy + 1;
      sum = 0;
      for (i = 0; i < AVG_DEPTH; i++) sum += int'(ring_copy[i]);
      avg  = sum / AVG_DEPTH;
      snum = 3 * avg - 7 * int'(cal4_copy) + 4 * int'(cal7_copy);
      num  = (snum < 0) ? -snum : snum;
      den  = (cal7_copy >= cal4_copy) ? int'(cal7_copy) - int'(cal4_copy)
                                      : int'(cal4_copy) - int'(cal7_copy);
      if (den == 0) begin
         centi = CENTI_MAX;
         whole = WHOLE_MAX;
      end else begin
         centi = (CENTI_SCALE * num) / den;
         if (centi > CENTI_MAX) centi = CENTI_MAX;
         whole = num / den;
         if (whole > WHOLE_MAX) whole = WHOLE_MAX;
      end
      // lower threshold wraps when the band is wider than the target
      up   = (int'(target_copy) + int'(hyst_copy)) & 'hFFFF;
      down = (int'(target_copy) - int'(hyst_copy)) & 'hFFFF;
      case (mode_copy)
         MODE_IDLE: begin
            if (centi >= up) mode_copy = MODE_ACID;
            if (centi <= int'(crit_copy)) mode_copy = MODE_BASE;
         end
         MODE_ACID: if (centi <= down) mode_copy = MODE_IDLE;
         MODE_BASE: if (centi >= down) mode_copy = MODE_IDLE;
         default: ;
      endcase
      r.centi = CENTI_W'(centi);
      r.whole = WHOLE_W'(whole);
      r.hund  = HUND_W'(centi % CENTI_SCALE);
      r.mode  = mode_copy;
      r.acid  = (mode_copy == MODE_ACID);
      r.base  = (mode_copy == MODE_BASE);
      r.err   = (den == 0);
      return r;
   endfunction

   task automatic note_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("tb: mismatch at reading %0d: %s got %0d want %0d",
               readings_seen, what, got, want);
   endtask

   // Register write, only once every reading in flight has come out
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_CALIB_PH4:   cal4_copy   = val[CAL_W-1:0];
         CSR_CALIB_PH7:   cal7_copy   = val[CAL_W-1:0];
         CSR_TARGET_PH:   target_copy = val[PH_W-1:0];
         CSR_HYSTERESIS:  hyst_copy   = val[PH_W-1:0];
         CSR_CRITICAL_PH: crit_copy   = val[PH_W-1:0];
         default: ;
      endcase
      csr_we <= 1'b0;
      writes_done++;
   endtask

   // One sample beat; tvalid drops when the sender takes a gap or before a register write
   task automatic send_sample(input logic [ADC_W-1:0] sample, input logic typed,
                              input ph_reading_type want);
      ph_reading_type pred;
      while ($urandom_range(0, 99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'(sample);
      do @(posedge clock); while (!req_tready);
      pred = ph_predict(sample);
      if (typed) pending_readings.push_back(want);
      else pending_readings.push_back(pred);
      samples_sent++;
   endtask

   function automatic void add_cfg(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] val);
      stim_row_type r;
      r.is_cfg = 1'b1;
      r.idx    = idx;
      r.val    = val;
      r.typed  = 1'b0;
      directed_rows.push_back(r);
   endfunction

   function automatic void add_smp(input logic [ADC_W-1:0] sample, input logic typed,
                                   input ph_reading_type want);
      stim_row_type r;
      r.is_cfg = 1'b0;
      r.idx    = '0;
      r.val    = CSR_DATA_W'(sample);
      r.typed  = typed;
      r.want   = want;
      directed_rows.push_back(r);
   endfunction

   // Result side: random back-pressure, field-by-field compare
   always @(posedge clock) begin
      ph_reading_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         readings_seen++;
         if (pending_readings.size() == 0) begin
            note_mismatch("beat with nothing pending, ph_centi",
                          longint'(rsp_tdata[15:0]), longint'(0));
         end else begin
            w = pending_readings.pop_front();
            if (w.mode == MODE_ACID) acid_seen++;
            if (w.mode == MODE_BASE) base_seen++;
            if (w.err) err_seen++;
            if (rsp_tdata[15:0] !== w.centi)
               note_mismatch("ph_centi", longint'(rsp_tdata[15:0]), longint'(w.centi));
            if (rsp_tdata[23:16] !== w.whole)
               note_mismatch("ph_whole", longint'(rsp_tdata[23:16]), longint'(w.whole));
            if (rsp_tdata[30:24] !== w.hund)
               note_mismatch("ph_hundredths", longint'(rsp_tdata[30:24]),
                             longint'(w.hund));
            if (rsp_tdata[32:31] !== w.mode)
               note_mismatch("valve_mode", longint'(rsp_tdata[32:31]), longint'(w.mode));
            if (rsp_tdata[33] !== w.acid)
               note_mismatch("acid_valve", longint'(rsp_tdata[33]), longint'(w.acid));
            if (rsp_tdata[34] !== w.base)
               note_mismatch("base_valve", longint'(rsp_tdata[34]), longint'(w.base));
            if (rsp_tdata[RSP_TDATA_W-1:RSP_FIELD_W] !== '0)
               note_mismatch("tdata padding",
                             longint'(rsp_tdata[RSP_TDATA_W-1:RSP_FIELD_W]), longint'(0));
            if (rsp_tuser[0] !== w.err)
               note_mismatch("calib_error", longint'(rsp_tuser[0]), longint'(w.err));
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= rcv_idle);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   initial begin
      ph_reading_type err_acid;
      ph_reading_type none;
      logic [CAL_W-1:0]  c4, c7;
      logic [PH_W-1:0]   tg, hy, cr;
      logic [ADC_W-1:0]  sample;
      int level, dir, step, k, per_phase;

      none = '{centi: '0, whole: '0, hund: '0, mode: MODE_IDLE, acid: 1'b0, base: 1'b0,
               err: 1'b0};
      // reset leaves both calibration points at zero: error path, valve goes acid
      err_acid = '{centi: CENTI_W'(CENTI_MAX), whole: WHOLE_W'(WHOLE_MAX),
                   hund: HUND_W'(HUND_SAT), mode: MODE_ACID, acid: 1'b1, base: 1'b0,
                   err: 1'b1};

      // Directed table
      add_smp(10'd0, 1'b1, err_acid);
      add_smp(10'd1023, 1'b1, err_acid);
      add_cfg(CSR_CALIB_PH7, 11'd1023);
      add_smp(10'd1023, 1'b0, none);
      add_smp(10'd1023, 1'b0, none);
      add_smp(10'd0, 1'b0, none);
      // reversed extremes of the calibration points
      add_cfg(CSR_CALIB_PH4, 11'd1023);
      add_cfg(CSR_CALIB_PH7, 11'd0);
      add_smp(10'd0, 1'b0, none);
      add_smp(10'd0, 1'b0, none);
      add_smp(10'd0, 1'b0, none);
      // writes to unused indexes change nothing
      add_cfg(CSR_SPARE_5, 11'd2047);
      add_cfg(CSR_SPARE_6, 11'd0);
      add_cfg(CSR_SPARE_7, 11'd1365);
      // one count between points: quotient saturates
      add_cfg(CSR_CALIB_PH4, 11'd0);
      add_cfg(CSR_CALIB_PH7, 11'd1);
      for (k = 0; k < 6; k++) add_smp(10'd1023, 1'b0, none);
      // band wider than target: lower threshold wraps
      add_cfg(CSR_TARGET_PH, 11'd10);
      add_cfg(CSR_HYSTERESIS, 11'd1400);
      add_cfg(CSR_CRITICAL_PH, 11'd0);
      add_smp(10'd1023, 1'b0, none);
      add_smp(10'd1023, 1'b0, none);
      add_smp(10'd0, 1'b0, none);
      add_smp(10'd0, 1'b0, none);
      // top thresholds, then equal points again
      add_cfg(CSR_TARGET_PH, 11'd1400);
      add_cfg(CSR_HYSTERESIS, 11'd0);
      add_cfg(CSR_CRITICAL_PH, 11'd1400);
      add_cfg(CSR_CALIB_PH7, 11'd0);
      add_smp(10'd512, 1'b0, none);
      add_smp(10'd341, 1'b0, none);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_cfg)
            csr_write(directed_rows[i].idx, directed_rows[i].val);
         else
            send_sample(directed_rows[i].val[ADC_W-1:0], directed_rows[i].typed,
                        directed_rows[i].want);
      end

      // Random part: one register setting per phase, drifting probe signal
      level     = 512;
      dir       = 1;
      per_phase = RANDOM_ITEMS / PHASES;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin c4 = 620;  c7 = 410;  tg = 700;  hy = 20;   cr = 600;  end
            1: begin c4 = 300;  c7 = 700;  tg = 650;  hy = 50;   cr = 550;  end
            3: begin c4 = 0;    c7 = 1023; tg = 1400; hy = 1400; cr = 1400; end
            4: begin c4 = 1023; c7 = 0;    tg = 0;    hy = 0;    cr = 0;    end
            5: begin
               c4 = CAL_W'($urandom_range(0, 1023));
               c7 = c4;
               tg = PH_W'($urandom_range(0, 1400));
               hy = PH_W'($urandom_range(0, 1400));
               cr = PH_W'($urandom_range(0, 1400));
            end
            default: begin
               c4 = CAL_W'($urandom_range(0, 1023));
               c7 = CAL_W'($urandom_range(0, 1023));
               tg = PH_W'($urandom_range(0, 1400));
               hy = PH_W'($urandom_range(0, 200));
               cr = PH_W'($urandom_range(0, 1400));
            end
         endcase
         csr_write(CSR_CALIB_PH4, CSR_DATA_W'(c4));
         csr_write(CSR_CALIB_PH7, CSR_DATA_W'(c7));
         csr_write(CSR_TARGET_PH, tg);
         csr_write(CSR_HYSTERESIS, hy);
         csr_write(CSR_CRITICAL_PH, cr);
         csr_write(CSR_IDX_W'($urandom_range(CSR_SPARE_5, CSR_SPARE_7)),
                   CSR_DATA_W'($urandom));

         for (k = 0; k < per_phase; k++) begin
            // idling pattern by thirds of the random part
            if (ph * per_phase + k < RANDOM_ITEMS / 3) begin
               snd_idle = 9;  rcv_idle = 63;
            end else if (ph * per_phase + k < 2 * RANDOM_ITEMS / 3) begin
               snd_idle = 63; rcv_idle = 9;
            end else begin
               snd_idle = 0;  rcv_idle = 0;
            end
            if ($urandom_range(0, 99) < 3) dir = -dir;
            if ($urandom_range(0, 99) < 4) begin
               level = $urandom_range(0, 1023);
            end else begin
               step  = $urandom_range(0, 24) - 8;
               level = level + dir * step;
               if (level < 0) begin level = 0; dir = 1; end
               if (level > 1023) begin level = 1023; dir = -1; end
            end
            if ($urandom_range(0, 99) < 10) begin
               sample = ADC_W'($urandom_range(0, 1023));
            end else begin
               step = level + $urandom_range(0, 16) - 8;
               if (step < 0) step = 0;
               if (step > 1023) step = 1023;
               sample = ADC_W'(step);
            end
            send_sample(sample, 1'b0, none);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d samples in, %0d readings checked, %0d register writes",
               samples_sent, readings_seen, writes_done);
      $display("tb: acid valve in %0d readings, base valve in %0d, calibration error in %0d",
               acid_seen, base_seen, err_seen);
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
